// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define PCLB_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds through reset
`define PCLB_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pclb_pkg.sv =====
`default_nettype none

package pclb_pkg;

  localparam int CELL_W    = 18;
  localparam int ID_W      = 12;
  localparam int COORD_W   = 24;
  localparam int GRID_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_ATOM_SLOTS = 4096;
  localparam int DEF_MAX_GRID   = 64;
  localparam int DEF_FRAC_BITS  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 2'd2;

  // neighbour offset codes along one axis
  localparam logic [1:0] OFS_MINUS = 2'd0;
  localparam logic [1:0] OFS_ZERO  = 2'd1;
  localparam logic [1:0] OFS_PLUS  = 2'd2;

  typedef enum logic {
    MODE_BIN   = 1'b0,
    MODE_NEIGH = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic [ID_W-1:0]           atom_id;
    logic signed [COORD_W-1:0] frac_x;
    logic signed [COORD_W-1:0] frac_y;
    logic signed [COORD_W-1:0] frac_z;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_index;
    logic              last;
    logic              all_atoms;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIV,
    ST_BIN_MUL,
    ST_BIN_SUM,
    ST_READ,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIV_X,
    DIV_Y,
    DIV_Z
  } div_pass_t;

endpackage

`default_nettype wire

// ===== rtl/periodic_cell_list_binner.sv =====
// Periodic cell-list binner. A bin item (mode 0) wraps the atom's fractional
// coordinates into one box, scales them by the grid sizes, stores the linear
// cell index in an on-chip table of ATOM_SLOTS entries and returns it as one
// result; it goes through capture, coordinate multiply, and index sum with
// table write. A neighbour item (mode 1) reads the atom's cell from the
// table, decodes it into x, y and z with one shared restoring divider that
// makes three passes of 18 steps each, then sends the 27 surrounding cells,
// z outermost and x innermost, one per cycle while result_stall is low,
// with last on the final one. If any grid size is below 3 every item
// returns a single result with all_atoms set, and a bin item stores
// nothing. Grid sizes of 0 act as 1 and sizes above MAX_GRID act as
// MAX_GRID. Grid registers are to be written only while the block is idle;
// cfg_ready is high whenever reset is low, and item_stall is high during
// reset. Querying an atom that was never binned returns unspecified cells.
// The table is not cleared at reset.
`default_nettype none

module periodic_cell_list_binner import pclb_pkg::*; #(
  parameter int ATOM_SLOTS = DEF_ATOM_SLOTS,
  parameter int MAX_GRID   = DEF_MAX_GRID,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GRID_W-1:0]    cfg_data
);

  localparam int G_W    = $clog2(MAX_GRID + 1);
  localparam int C_W    = $clog2(MAX_GRID);
  localparam int A_W    = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;
  localparam int EXT_W  = (A_W > ID_W) ? A_W : ID_W;
  localparam int STEP_W = $clog2(CELL_W);
  localparam int PROD_W = FRAC_BITS + G_W;
  localparam int XY_W   = 2 * G_W;
  localparam int SUM_W  = C_W + XY_W + 2;

  function automatic logic [G_W-1:0] eff_grid(input logic [GRID_W-1:0] g);
    logic [G_W-1:0] r;
    if (g == '0) begin
      r = G_W'(1);
    end else if (32'(g) > 32'(MAX_GRID)) begin
      r = G_W'(MAX_GRID);
    end else begin
      r = G_W'(g);
    end
    return r;
  endfunction

  function automatic logic [C_W-1:0] bin_coord(input logic [COORD_W-1:0] raw,
                                               input logic [G_W-1:0] g);
    logic [FRAC_BITS-1:0] f;
    logic [PROD_W-1:0]    p;
    logic [G_W-1:0]       c;
    f = raw[FRAC_BITS-1:0];
    p = PROD_W'(f) * PROD_W'(g);
    c = p[PROD_W-1:FRAC_BITS];
    if (c >= g) begin
      c = g - G_W'(1);
    end
    return C_W'(c);
  endfunction

  function automatic logic [C_W-1:0] wrap_step(input logic [C_W-1:0] o,
                                               input logic [1:0] ofs,
                                               input logic [G_W-1:0] g);
    logic [C_W-1:0] r;
    logic [G_W-1:0] up;
    up = G_W'(o) + G_W'(1);
    r  = o;
    if (ofs == OFS_MINUS) begin
      r = (o == '0) ? C_W'(g - G_W'(1)) : o - C_W'(1);
    end else if (ofs == OFS_PLUS) begin
      r = (up >= g) ? '0 : C_W'(up);
    end
    return r;
  endfunction

  state_t                 state, state_next;
  item_t                  cur;
  logic [GRID_W-1:0]      grid_x, grid_y, grid_z;
  logic [G_W-1:0]         gx, gy, gz, div_g;
  logic [XY_W-1:0]        gxy;
  logic                   trivial;
  logic [C_W-1:0]         cx, cy, cz;
  logic [C_W-1:0]         ox, oy, oz;
  logic [C_W-1:0]         nx, ny, nz;
  logic [1:0]             dx, dy, dz;
  logic [CELL_W-1:0]      num;
  logic [G_W-1:0]         rem, rem_next;
  logic [G_W:0]           trial;
  logic                   q_bit;
  logic [STEP_W-1:0]      step;
  div_pass_t              pass;
  logic                   accept, slot_free, res_load, mem_we, nb_last;
  logic                   cur_in_range;
  logic [EXT_W-1:0]       item_id_ext, cur_id_ext;
  logic [SUM_W-1:0]       bin_sum, nb_sum;
  result_t                res_next;

  logic [CELL_W-1:0]      mem [ATOM_SLOTS];
  logic [CELL_W-1:0]      rd_data;

  assign cfg_ready = !rst;

  assign gx      = eff_grid(grid_x);
  assign gy      = eff_grid(grid_y);
  assign gz      = eff_grid(grid_z);
  assign trivial = (gx < G_W'(3)) || (gy < G_W'(3)) || (gz < G_W'(3));

  assign item_stall = rst || (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign slot_free  = !result_valid || !result_stall;

  assign item_id_ext  = EXT_W'(item.atom_id);
  assign cur_id_ext   = EXT_W'(cur.atom_id);
  assign cur_in_range = (32'(cur.atom_id) < 32'(ATOM_SLOTS));

  // divider step
  always_comb begin
    unique case (pass)
      DIV_X:   div_g = gx;
      DIV_Y:   div_g = gy;
      DIV_Z:   div_g = gz;
      default: div_g = gz;
    endcase
    trial    = {rem, num[CELL_W-1]};
    q_bit    = (trial >= {1'b0, div_g});
    rem_next = q_bit ? G_W'(trial - {1'b0, div_g}) : G_W'(trial);
  end

  assign bin_sum = SUM_W'(cx) + SUM_W'(cy) * SUM_W'(gx) + SUM_W'(cz) * SUM_W'(gxy);

  assign nx      = wrap_step(ox, dx, gx);
  assign ny      = wrap_step(oy, dy, gy);
  assign nz      = wrap_step(oz, dz, gz);
  assign nb_sum  = SUM_W'(nx) + SUM_W'(ny) * SUM_W'(gx) + SUM_W'(nz) * SUM_W'(gxy);
  assign nb_last = (dx == OFS_PLUS) && (dy == OFS_PLUS) && (dz == OFS_PLUS);

  always_comb begin
    state_next = state;
    res_load   = 1'b0;
    mem_we     = 1'b0;
    res_next   = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (trivial) begin
            state_next = ST_TRIV;
          end else if (item.mode == MODE_BIN) begin
            state_next = ST_BIN_MUL;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_TRIV: begin
        if (slot_free) begin
          res_load           = 1'b1;
          res_next.last      = 1'b1;
          res_next.all_atoms = 1'b1;
          state_next         = ST_IDLE;
        end
      end
      ST_BIN_MUL: begin
        state_next = ST_BIN_SUM;
      end
      ST_BIN_SUM: begin
        if (slot_free) begin
          res_load            = 1'b1;
          mem_we              = cur_in_range;
          res_next.cell_index = CELL_W'(bin_sum);
          res_next.last       = 1'b1;
          state_next          = ST_IDLE;
        end
      end
      ST_READ: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (pass == DIV_Z && step == STEP_W'(CELL_W - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          res_load            = 1'b1;
          res_next.cell_index = CELL_W'(nb_sum);
          res_next.last       = nb_last;
          if (nb_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      grid_x       <= GRID_W'(1);
      grid_y       <= GRID_W'(1);
      grid_z       <= GRID_W'(1);
    end else begin
      state <= state_next;
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GRID_X: grid_x <= cfg_data;
          REG_GRID_Y: grid_y <= cfg_data;
          REG_GRID_Z: grid_z <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    gxy <= XY_W'(gx) * XY_W'(gy);
    if (accept) begin
      cur <= item;
    end
    if (res_load) begin
      result <= res_next;
    end
    if (state == ST_BIN_MUL) begin
      cx <= bin_coord(cur.frac_x, gx);
      cy <= bin_coord(cur.frac_y, gy);
      cz <= bin_coord(cur.frac_z, gz);
    end
    if (state == ST_READ) begin
      num  <= cur_in_range ? rd_data : '0;
      rem  <= '0;
      step <= '0;
      pass <= DIV_X;
    end
    if (state == ST_DIV) begin
      num <= {num[CELL_W-2:0], q_bit};
      if (step == STEP_W'(CELL_W - 1)) begin
        rem  <= '0;
        step <= '0;
        unique case (pass)
          DIV_X: begin
            ox   <= C_W'(rem_next);
            pass <= DIV_Y;
          end
          DIV_Y: begin
            oy   <= C_W'(rem_next);
            pass <= DIV_Z;
          end
          default: begin
            oz <= C_W'(rem_next);
            dx <= OFS_MINUS;
            dy <= OFS_MINUS;
            dz <= OFS_MINUS;
          end
        endcase
      end else begin
        rem  <= rem_next;
        step <= step + STEP_W'(1);
      end
    end
    if (state == ST_EMIT && res_load) begin
      if (dx == OFS_PLUS) begin
        dx <= OFS_MINUS;
        if (dy == OFS_PLUS) begin
          dy <= OFS_MINUS;
          dz <= dz + 2'd1;
        end else begin
          dy <= dy + 2'd1;
        end
      end else begin
        dx <= dx + 2'd1;
      end
    end
  end

  // cell table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_id_ext[A_W-1:0]] <= res_next.cell_index;
    end
    if (accept) begin
      rd_data <= mem[item_id_ext[A_W-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pclb_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module pclb_checker import pclb_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  `PCLB_ASSERT_ALWAYS(a_reset_clears_result, clk, rst |=> !result_valid, "result valid after reset")

  `PCLB_ASSERT(a_busy_after_accept, clk, rst, item_valid && !item_stall |=> item_stall, "second transfer taken while busy")

  `PCLB_ASSERT(a_all_atoms_single, clk, rst, result_valid && result.all_atoms |-> result.last && result.cell_index == '0, "all-atoms result not a single zero result")

  `PCLB_ASSERT(a_neighbours_back_to_back, clk, rst, result_valid && !result_stall && !result.last |=> result_valid, "gap inside a neighbour burst")

  `PCLB_ASSERT(a_result_held, clk, rst, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

endmodule

bind periodic_cell_list_binner pclb_checker u_pclb_checker (.*);

`default_nettype wire
